// ===== rtl/core/twp_pkg.sv =====
// ----------------------------------------------------------------------------
// twp_pkg
// Shared types and constants of the timed waveform playback core.
// ----------------------------------------------------------------------------
package twp_pkg;

   localparam int MAX_SAMPLES  = 4096;
   localparam int MAX_ELEMENTS = 8;
   localparam int SAMPLE_W     = 12;
   localparam int ELEM_W       = 3;
   localparam int EPS_W        = 4;
   localparam int COUNT_W      = 13;
   localparam int TIME_W       = 48;
   localparam int VALUE_W      = 32;
   localparam int VADDR_W      = SAMPLE_W + ELEM_W;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   // request modes
   localparam logic [1:0] MODE_LOAD_TIME  = 2'd0;
   localparam logic [1:0] MODE_LOAD_VALUE = 2'd1;
   localparam logic [1:0] MODE_QUERY      = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENTS     = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_L_RD0, ST_L_RDL, ST_L_CHKL, ST_L_SRCH, ST_L_STEP, ST_L_RDS,
      ST_L_RDS1, ST_L_GOTT, ST_E_RD0, ST_E_RD1, ST_E_LAT, ST_E_PREP, ST_E_WAIT,
      ST_E_OUTL, ST_E_OUTV0, ST_N_RD, ST_N_CHK, ST_N_SRCH, ST_N_STEP, ST_N_RDS,
      ST_N_CMP, ST_NE_START, ST_NE_RD, ST_NE_CAP, ST_NE_OUT, ST_Z_OUT
   } state_type;

   typedef enum logic [2:0] {
      LS_IDLE, LS_MUL, LS_DIV, LS_RND, LS_FIN
   } lerp_state_type;

   typedef enum logic [1:0] {TA_ZERO, TA_LAST, TA_S, TA_S1} taddr_sel_type;
   typedef enum logic [1:0] {VA_S, VA_S1, VA_PICK} vaddr_sel_type;
   typedef enum logic [1:0] {OS_ZERO, OS_V0, OS_LERP} out_src_type;

   typedef struct packed {
      logic          req_ready;
      taddr_sel_type taddr_sel;
      vaddr_sel_type vaddr_sel;
      logic          cap_ta;
      logic          cap_tb;
      logic          cap_v0;
      logic          cap_v1;
      logic          s_inc;
      logic          set_pick;
      logic          pick_s1;
      logic          save_ptr;
      logic          flag_upd;
      logic          flag_ended;
      logic          elem_clr;
      logic          elem_inc;
      logic          lerp_start;
      logic          out_load;
      out_src_type   out_src;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_query;
      logic near_mode;
      logic t_gt_q;
      logic t_lt_q;
      logic near_left;
      logic s_lt_nm2;
      logic s_lt_nm1;
      logic s_is_zero;
      logic s_is_nm1;
      logic d_le_0;
      logic lerp_done;
      logic out_free;
      logic elem_last;
   } status_type;

endpackage

// ===== rtl/core/twp_if.sv =====
// ----------------------------------------------------------------------------
// twp_req_if / twp_rsp_if
// Valid/ready channels for requests and results of the playback core.
// ----------------------------------------------------------------------------
interface twp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] index;
   logic [2:0]  element;
   logic signed [47:0] time_us;
   logic signed [31:0] sample_value;

   modport source (output valid, mode, index, element, time_us, sample_value,
                   input ready);
   modport sink (input valid, mode, index, element, time_us, sample_value,
                 output ready);
endinterface

interface twp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] out_value;
   logic [2:0]  out_element;
   logic        last;
   logic        ended;
   logic        ended_notice;

   modport source (output valid, out_value, out_element, last, ended, ended_notice,
                   input ready);
   modport sink (input valid, out_value, out_element, last, ended, ended_notice,
                 output ready);
endinterface

// ===== rtl/core/twp_ram.sv =====
// ----------------------------------------------------------------------------
// twp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module twp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/twp_lerp.sv =====
// ----------------------------------------------------------------------------
// twp_lerp
// Interpolation unit: v0 + dt*(v1-v0)/d, rounded half away from zero,
// saturated. Shift-add multiply then restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module twp_lerp (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] v0,
   input  logic signed [31:0] v1,
   input  logic signed [48:0] dt,
   input  logic [47:0]        d,
   output logic               done,
   output logic signed [31:0] result
);
   import twp_pkg::*;

   localparam int A_W   = 48;
   localparam int B_W   = 32;
   localparam int P_W   = A_W + B_W;
   localparam int Q_W   = 41;
   localparam int CNT_W = $clog2(P_W);

   lerp_state_type state_ff, state_in;
   logic [P_W-1:0]   acc_ff, acc_in, mcand_ff, mcand_in;
   logic [B_W-1:0]   mplier_ff, mplier_in;
   logic [A_W-1:0]   c_ff, c_in, rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in, sat_ff, sat_in, done_ff, done_in;
   logic signed [31:0] v0_ff, v0_in, result_ff, result_in;
   logic [Q_W-1:0]   qmag_ff, qmag_in;

   logic signed [32:0] dv;
   logic [A_W:0]       rem_sh;
   logic [P_W:0]       q_rnd;
   logic               round_up;
   logic signed [Q_W:0] r_sum;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LS_IDLE: if (start) state_in = LS_MUL;
         LS_MUL:  if (cnt_ff == CNT_W'(B_W - 1)) state_in = LS_DIV;
         LS_DIV:  if (cnt_ff == CNT_W'(P_W - 1)) state_in = LS_RND;
         LS_RND:  state_in = LS_FIN;
         LS_FIN:  state_in = LS_IDLE;
         default: state_in = LS_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      c_in      = c_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      sat_in    = sat_ff;
      v0_in     = v0_ff;
      qmag_in   = qmag_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      dv        = {v1[31], v1} - {v0[31], v0};
      rem_sh    = {rem_ff, acc_ff[P_W-1]};
      round_up  = ({1'b0, rem_ff} >= ({1'b0, c_ff} - {1'b0, rem_ff}));
      q_rnd     = {1'b0, acc_ff} + {{P_W{1'b0}}, round_up};
      r_sum     = {{(Q_W-31){v0_ff[31]}}, v0_ff} + (neg_ff ? -$signed({1'b0, qmag_ff})
                                                           :  $signed({1'b0, qmag_ff}));
      unique case (state_ff)
         LS_IDLE: begin
            if (start) begin
               neg_in    = dt[48] ^ dv[32];
               mcand_in  = {{B_W{1'b0}}, dt[48] ? A_W'(-dt) : dt[A_W-1:0]};
               mplier_in = dv[32] ? B_W'(-dv) : dv[B_W-1:0];
               acc_in    = '0;
               c_in      = d;
               v0_in     = v0;
               cnt_in    = '0;
            end
         end
         LS_MUL: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = (cnt_ff == CNT_W'(B_W - 1)) ? '0 : cnt_ff + 1'b1;
            rem_in    = '0;
         end
         LS_DIV: begin
            if (rem_sh >= {1'b0, c_ff}) begin
               rem_in = A_W'(rem_sh - {1'b0, c_ff});
               acc_in = {acc_ff[P_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[A_W-1:0];
               acc_in = {acc_ff[P_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         LS_RND: begin
            sat_in  = (q_rnd > (P_W+1)'(64'd1 << 40));
            qmag_in = q_rnd[Q_W-1:0];
         end
         LS_FIN: begin
            done_in = 1'b1;
            if (sat_ff || r_sum > 42'sd2147483647 || r_sum < -42'sd2147483648) begin
               result_in = (sat_ff ? neg_ff : r_sum[Q_W]) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
               result_in = r_sum[31:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      c_ff      <= c_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      sat_ff    <= sat_in;
      v0_ff     <= v0_in;
      qmag_ff   <= qmag_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

   // start only while idle, done lasts one cycle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == LS_IDLE) else $error("lerp start while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("lerp done longer than one cycle");
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff) == LS_FIN) else $error("lerp done without finish");
endmodule

// ===== rtl/core/twp_datapath.sv =====
// ----------------------------------------------------------------------------
// twp_datapath
// Stores, registers, search pointer, interpolation unit and result register.
// ----------------------------------------------------------------------------
module twp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   twp_req_if.sink                         req_chan,
   twp_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [twp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  twp_pkg::cmd_type                cmd,
   output twp_pkg::status_type             status
);
   import twp_pkg::*;

   logic                 interp_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [EPS_W-1:0]     eps_ff;
   logic [SAMPLE_W-1:0]  ptr_ff, s_ff, pick_ff, nm1, nm2, p_lin, p_near, taddr;
   logic [ELEM_W-1:0]    elem_ff, elem_last;
   logic                 notified_ff, ended_ff, notice_ff;
   logic signed [TIME_W-1:0]  qt_ff, ta_ff, tb_ff, trd;
   logic signed [VALUE_W-1:0] v0_ff, v1_ff, lerp_res;
   logic [TIME_W-1:0]    t_rdata;
   logic [VALUE_W-1:0]   v_rdata;
   logic [VADDR_W-1:0]   vaddr;
   logic                 accept, lerp_done;
   logic signed [TIME_W:0] dt, dd, near_l, near_r;
   logic                 rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [ELEM_W-1:0]    rsp_elem_ff;
   logic                 rsp_last_ff, rsp_ended_ff, rsp_notice_ff;

   assign accept         = req_chan.valid && cmd.req_ready;
   assign req_chan.ready = cmd.req_ready;

   // clamped register views
   always_comb begin
      if (count_ff < COUNT_W'(2)) nm1 = SAMPLE_W'(1);
      else if (count_ff > COUNT_W'(MAX_SAMPLES)) nm1 = SAMPLE_W'(MAX_SAMPLES - 1);
      else nm1 = SAMPLE_W'(count_ff - 1'b1);
      nm2 = nm1 - 1'b1;
      if (eps_ff == '0) elem_last = '0;
      else if (eps_ff > EPS_W'(MAX_ELEMENTS)) elem_last = ELEM_W'(MAX_ELEMENTS - 1);
      else elem_last = ELEM_W'(eps_ff - 1'b1);
      p_lin  = (ptr_ff < nm2) ? ptr_ff : nm2;
      p_near = (ptr_ff < nm1) ? ptr_ff : nm1;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= 1'b0;
         count_ff  <= COUNT_W'(2);
         eps_ff    <= EPS_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INTERP_MODE:  interp_ff <= csr_wdata[0];
            CSR_SAMPLE_COUNT: count_ff  <= csr_wdata;
            CSR_ELEMENTS:     eps_ff    <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // store address selection
   always_comb begin
      unique case (cmd.taddr_sel)
         TA_ZERO: taddr = '0;
         TA_LAST: taddr = nm1;
         TA_S:    taddr = s_ff;
         TA_S1:   taddr = s_ff + 1'b1;
         default: taddr = '0;
      endcase
      unique case (cmd.vaddr_sel)
         VA_S:    vaddr = {s_ff, elem_ff};
         VA_S1:   vaddr = {s_ff + 1'b1, elem_ff};
         VA_PICK: vaddr = {pick_ff, elem_ff};
         default: vaddr = {pick_ff, elem_ff};
      endcase
   end

   twp_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SAMPLES)) u_time_ram (
      .clock (clock),
      .we    (accept && req_chan.mode == MODE_LOAD_TIME),
      .waddr (req_chan.index),
      .wdata (req_chan.time_us),
      .raddr (taddr),
      .rdata (t_rdata)
   );

   twp_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_SAMPLES * MAX_ELEMENTS)) u_value_ram (
      .clock (clock),
      .we    (accept && req_chan.mode == MODE_LOAD_VALUE),
      .waddr ({req_chan.index, req_chan.element}),
      .wdata (req_chan.sample_value),
      .raddr (vaddr),
      .rdata (v_rdata)
   );

   assign trd    = $signed(t_rdata);
   assign dt     = {qt_ff[TIME_W-1], qt_ff} - {ta_ff[TIME_W-1], ta_ff};
   assign dd     = {tb_ff[TIME_W-1], tb_ff} - {ta_ff[TIME_W-1], ta_ff};
   assign near_l = {qt_ff[TIME_W-1], qt_ff} - {trd[TIME_W-1], trd};
   assign near_r = {tb_ff[TIME_W-1], tb_ff} - {qt_ff[TIME_W-1], qt_ff};

   twp_lerp u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.lerp_start),
      .v0     (v0_ff),
      .v1     (v1_ff),
      .dt     (dt),
      .d      (dd[TIME_W-1:0]),
      .done   (lerp_done),
      .result (lerp_res)
   );

   // query working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         qt_ff <= req_chan.time_us;
         s_ff  <= interp_ff ? p_near : p_lin;
      end else if (cmd.s_inc) begin
         s_ff <= s_ff + 1'b1;
      end
      if (cmd.cap_ta) ta_ff <= trd;
      if (cmd.cap_tb) tb_ff <= trd;
      if (cmd.cap_v0) v0_ff <= $signed(v_rdata);
      if (cmd.cap_v1) v1_ff <= $signed(v_rdata);
      if (cmd.set_pick) pick_ff <= cmd.pick_s1 ? s_ff + 1'b1 : s_ff;
      if (cmd.elem_clr) elem_ff <= '0;
      else if (cmd.elem_inc) elem_ff <= elem_ff + 1'b1;
   end

   // search pointer and end notice
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         notified_ff <= 1'b0;
         ended_ff    <= 1'b0;
         notice_ff   <= 1'b0;
      end else begin
         if (accept && (req_chan.mode == MODE_LOAD_TIME || req_chan.mode == MODE_LOAD_VALUE))
         begin
            ptr_ff      <= '0;
            notified_ff <= 1'b0;
         end else begin
            if (cmd.save_ptr) ptr_ff <= s_ff;
            if (cmd.flag_upd) begin
               ended_ff    <= cmd.flag_ended;
               notice_ff   <= cmd.flag_ended && !notified_ff;
               notified_ff <= cmd.flag_ended;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         unique case (cmd.out_src)
            OS_ZERO: rsp_value_ff <= '0;
            OS_V0:   rsp_value_ff <= v0_ff;
            OS_LERP: rsp_value_ff <= lerp_res;
            default: rsp_value_ff <= '0;
         endcase
         rsp_elem_ff   <= elem_ff;
         rsp_last_ff   <= (elem_ff == elem_last);
         rsp_ended_ff  <= ended_ff;
         rsp_notice_ff <= notice_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_value    = rsp_value_ff;
   assign rsp_chan.out_element  = rsp_elem_ff;
   assign rsp_chan.last         = rsp_last_ff;
   assign rsp_chan.ended        = rsp_ended_ff;
   assign rsp_chan.ended_notice = rsp_notice_ff;

   // status toward the controller
   always_comb begin
      status.req_valid = req_chan.valid;
      status.req_query = (req_chan.mode == MODE_QUERY);
      status.near_mode = interp_ff;
      status.t_gt_q    = trd > qt_ff;
      status.t_lt_q    = trd < qt_ff;
      status.near_left = near_l < near_r;
      status.s_lt_nm2  = s_ff < nm2;
      status.s_lt_nm1  = s_ff < nm1;
      status.s_is_zero = (s_ff == '0);
      status.s_is_nm1  = (s_ff == nm1);
      status.d_le_0    = dd[TIME_W] || (dd == '0);
      status.lerp_done = lerp_done;
      status.out_free  = !rsp_valid_ff || rsp_chan.ready;
      status.elem_last = (elem_ff == elem_last);
   end
endmodule

// ===== rtl/core/twp_ctrl.sv =====
// ----------------------------------------------------------------------------
// twp_ctrl
// Sequencer: search over the time store, per-element read, interpolate, emit.
// ----------------------------------------------------------------------------
module twp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  twp_pkg::status_type  status,
   output twp_pkg::cmd_type     cmd
);
   import twp_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (status.req_valid && status.req_query)
               state_in = status.near_mode ? ST_N_RD : ST_L_RD0;
         ST_L_RD0:  state_in = ST_L_RDL;
         ST_L_RDL:  state_in = status.t_gt_q ? ST_Z_OUT : ST_L_CHKL;
         ST_L_CHKL: state_in = status.t_lt_q ? ST_Z_OUT : ST_L_SRCH;
         ST_L_SRCH: state_in = status.s_lt_nm2 ? ST_L_STEP : ST_L_RDS;
         ST_L_STEP: state_in = status.t_lt_q ? ST_L_SRCH : ST_L_RDS;
         ST_L_RDS:  state_in = ST_L_RDS1;
         ST_L_RDS1: state_in = ST_L_GOTT;
         ST_L_GOTT: state_in = ST_E_RD0;
         ST_E_RD0:  state_in = ST_E_RD1;
         ST_E_RD1:  state_in = ST_E_LAT;
         ST_E_LAT:  state_in = ST_E_PREP;
         ST_E_PREP: state_in = status.d_le_0 ? ST_E_OUTV0 : ST_E_WAIT;
         ST_E_WAIT: if (status.lerp_done) state_in = ST_E_OUTL;
         ST_E_OUTL, ST_E_OUTV0:
            if (status.out_free) state_in = status.elem_last ? ST_IDLE : ST_E_RD0;
         ST_N_RD:   state_in = ST_N_CHK;
         ST_N_CHK:
            if ((status.s_is_zero && status.t_gt_q) || (status.s_is_nm1 && status.t_lt_q))
               state_in = ST_Z_OUT;
            else
               state_in = ST_N_SRCH;
         ST_N_SRCH: state_in = status.s_lt_nm1 ? ST_N_STEP : ST_NE_START;
         ST_N_STEP: state_in = status.t_gt_q ? ST_N_RDS : ST_N_SRCH;
         ST_N_RDS:  state_in = ST_N_CMP;
         ST_N_CMP:  state_in = ST_NE_START;
         ST_NE_START: state_in = ST_NE_RD;
         ST_NE_RD:  state_in = ST_NE_CAP;
         ST_NE_CAP: state_in = ST_NE_OUT;
         ST_NE_OUT:
            if (status.out_free) state_in = status.elem_last ? ST_IDLE : ST_NE_RD;
         ST_Z_OUT:
            if (status.out_free && status.elem_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.taddr_sel = TA_ZERO;
      cmd.vaddr_sel = VA_PICK;
      cmd.out_src   = OS_ZERO;
      unique case (state_ff)
         ST_IDLE:  cmd.req_ready = 1'b1;
         ST_L_RD0: cmd.taddr_sel = TA_ZERO;
         ST_L_RDL: begin
            cmd.taddr_sel = TA_LAST;
            if (status.t_gt_q) begin
               cmd.flag_upd = 1'b1;
               cmd.elem_clr = 1'b1;
            end
         end
         ST_L_CHKL: begin
            if (status.t_lt_q) begin
               cmd.flag_upd   = 1'b1;
               cmd.flag_ended = 1'b1;
               cmd.elem_clr   = 1'b1;
            end
         end
         ST_L_SRCH: cmd.taddr_sel = TA_S1;
         ST_L_STEP: cmd.s_inc = status.t_lt_q;
         ST_L_RDS:  cmd.taddr_sel = TA_S;
         ST_L_RDS1: begin
            cmd.taddr_sel = TA_S1;
            cmd.cap_ta    = 1'b1;
         end
         ST_L_GOTT: begin
            cmd.cap_tb   = 1'b1;
            cmd.save_ptr = 1'b1;
            cmd.flag_upd = 1'b1;
            cmd.elem_clr = 1'b1;
         end
         ST_E_RD0: cmd.vaddr_sel = VA_S;
         ST_E_RD1: begin
            cmd.vaddr_sel = VA_S1;
            cmd.cap_v0    = 1'b1;
         end
         ST_E_LAT:  cmd.cap_v1 = 1'b1;
         ST_E_PREP: cmd.lerp_start = !status.d_le_0;
         ST_E_WAIT: ;
         ST_E_OUTL, ST_E_OUTV0, ST_NE_OUT, ST_Z_OUT: begin
            cmd.out_src = (state_ff == ST_E_OUTL) ? OS_LERP :
                          (state_ff == ST_Z_OUT)  ? OS_ZERO : OS_V0;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.elem_inc = !status.elem_last;
            end
         end
         ST_N_RD: cmd.taddr_sel = TA_S;
         ST_N_CHK: begin
            if (status.s_is_zero && status.t_gt_q) begin
               cmd.flag_upd = 1'b1;
               cmd.elem_clr = 1'b1;
            end else if (status.s_is_nm1 && status.t_lt_q) begin
               cmd.flag_upd   = 1'b1;
               cmd.flag_ended = 1'b1;
               cmd.elem_clr   = 1'b1;
            end
         end
         ST_N_SRCH: begin
            cmd.taddr_sel = TA_S1;
            cmd.set_pick  = !status.s_lt_nm1;
         end
         ST_N_STEP: begin
            cmd.s_inc  = !status.t_gt_q;
            cmd.cap_tb = status.t_gt_q;
         end
         ST_N_RDS: cmd.taddr_sel = TA_S;
         ST_N_CMP: begin
            cmd.set_pick = 1'b1;
            cmd.pick_s1  = !status.near_left;
         end
         ST_NE_START: begin
            cmd.save_ptr = 1'b1;
            cmd.flag_upd = 1'b1;
            cmd.elem_clr = 1'b1;
         end
         ST_NE_RD:  cmd.vaddr_sel = VA_PICK;
         ST_NE_CAP: cmd.cap_v0 = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free) else $error("result loaded over pending one");
   a_ready_no_load: assert property (@(posedge clock) disable iff (reset)
      cmd.req_ready |-> !cmd.out_load && !cmd.lerp_start)
      else $error("request taken during query work");
   a_wait_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E_WAIT && status.lerp_done) |=> state_ff == ST_E_OUTL)
      else $error("interpolation result not emitted");
endmodule

// ===== rtl/core/timed_waveform_playback_core.sv =====
// ----------------------------------------------------------------------------
// timed_waveform_playback_core
// Waveform store with forward search and per-element interpolation.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries load-time, load-value and query requests (valid/ready).
//  Loads write the time or value store and reset the search
//  pointer and end notice; they produce no result. A query produces one
//  result per element on rsp_chan, last set on the final one.
//  csr_* writes interp_mode, sample_count, elements_per_sample while idle.
//  After the accept, range checks run, then the search pointer advances
//  sample by sample and settles on the segment. Each element in linear
//  mode then runs the bit-serial 32-step multiply and 80-step divide of
//  the interpolation unit, skipped when the neighbor times do not rise;
//  nearest mode emits the picked sample's value, and zeros are emitted
//  outside the waveform.
//  One request is in work at a time; the next is taken once the final
//  result sits in the output register.
//  A stalled rsp_chan holds the result register and pauses the sequencer.
//  Reset clears control state, the pointer and config registers; store
//  contents are undefined until loaded, and no clearing pass is made.
// ----------------------------------------------------------------------------
module timed_waveform_playback_core (
   input  logic                            clock,
   input  logic                            reset,
   twp_req_if.sink                         req_chan,
   twp_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [twp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import twp_pkg::*;

   cmd_type    cmd;
   status_type status;

   twp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   twp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );
endmodule
